/* rtl/core/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and the sequencer state type of the sliding-window median
// filter.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

    // sample and window geometry
    localparam int SAMPLE_WIDTH = 32;
    localparam int WINDOW_MAX   = 64;
    localparam int IDX_W        = $clog2(WINDOW_MAX);
    localparam int CNT_W        = $clog2(WINDOW_MAX + 1);

    // width of the window size register
    localparam int CFG_W = 7;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REM_FETCH,
        ST_SCAN,
        ST_INS_FETCH,
        ST_INS,
        ST_MED_RD,
        ST_OUT_LOAD
    } state_t;

endpackage

`default_nettype wire

/* rtl/core/sliding_window_median.sv */
// ----------------------------------------------------------------------------
// sliding_window_median
// Running lower-median filter over the most recent window_size samples, with
// the window kept once in arrival order and once in ascending sorted order.
// ----------------------------------------------------------------------------
// Usage
// - s_axis carries one signed sample per item; s_axis_tlast marks the last
//   sample of a sequence, after which the window is emptied.
// - m_axis carries the lower median (rank (window_size-1)/2) once the window
//   of the current sequence is full; m_axis_tlast repeats the input's tlast.
// - cfg_we/cfg_wdata write window_size (0 acts as 1, above 64 acts as 64)
//   and empty the window; write only while the block is idle.
// Timing
// - one item is in work at a time; s_axis_tready is high only when idle.
// - a full window costs a removal scan over all window_size entries plus
//   an insertion walk, both through the sorted memory's single read and
//   write port, plus fetch and output.
// - while filling, an item skips the removal scan; the item that
//   completes the window also passes the median read and output load.
// Reset and stall
// - reset empties the window and sets window_size to 3; the sample memories
//   are not cleared, only written entries are ever read.
// - the result sits in an output register; the next item is accepted while
//   it waits, and the sequencer holds before its output load until it leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_median (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // window size register write
    input  wire logic                                  cfg_we,
    input  wire logic [swm_pkg::CFG_W-1:0]             cfg_wdata,
    // input items
    input  wire logic                                  s_axis_tvalid,
    output      logic                                  s_axis_tready,
    input  wire logic [swm_pkg::SAMPLE_WIDTH-1:0]      s_axis_tdata,   // [31:0] sample
    input  wire logic                                  s_axis_tlast,   // last_sample
    // result items
    output      logic                                  m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    output      logic [swm_pkg::SAMPLE_WIDTH-1:0]      m_axis_tdata,   // [31:0] median
    output      logic                                  m_axis_tlast    // sequence_end
);

    import swm_pkg::*;

    // sequencer and window bookkeeping
    state_t                          state_reg, state_next;
    logic [CFG_W-1:0]                window_size_reg;
    logic [CNT_W-1:0]                fill_reg, fill_next;
    logic [IDX_W-1:0]                oldest_reg, oldest_next;

    // per-item registers
    logic signed [SAMPLE_WIDTH-1:0]  sample_reg, sample_next;
    logic                            last_reg, last_next;
    logic                            produce_reg, produce_next;
    logic signed [SAMPLE_WIDTH-1:0]  old_reg, old_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic                            found_reg, found_next;
    logic [IDX_W-1:0]                pos_reg, pos_next;

    // output register
    logic                            out_valid_reg, out_valid_next;
    logic [SAMPLE_WIDTH-1:0]         out_data_reg, out_data_next;
    logic                            out_last_reg, out_last_next;

    // memories
    logic signed [SAMPLE_WIDTH-1:0]  win_mem [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0]  sort_mem [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0]  win_rdata_reg;
    logic signed [SAMPLE_WIDTH-1:0]  sort_rdata_reg;
    logic                            win_we;
    logic [IDX_W-1:0]                win_waddr, win_raddr;
    logic                            sort_we;
    logic [IDX_W-1:0]                sort_waddr, sort_raddr;
    logic signed [SAMPLE_WIDTH-1:0]  sort_wdata;

    // derived window values
    logic [CNT_W-1:0]                k_w;
    logic [CNT_W-1:0]                k_dec_w;
    logic [IDX_W-1:0]                k_m1_w;
    logic                            full_w;
    logic [IDX_W-1:0]                slot_w;
    logic [CNT_W-1:0]                slot_inc_w;
    logic [CNT_W-1:0]                fill_after_w;
    logic                            accept_w;
    logic                            scan_done_w;
    logic                            shift_w;
    logic                            out_load_w;

    // effective window size and slot selection
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            k_w = CNT_W'(1);
        end
        else if (int'(window_size_reg) > WINDOW_MAX)
        begin
            k_w = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            k_w = CNT_W'(window_size_reg);
        end
        k_dec_w      = k_w - CNT_W'(1);
        k_m1_w       = k_dec_w[IDX_W-1:0];
        full_w       = (fill_reg >= k_w);
        slot_w       = (CNT_W'(oldest_reg) < k_w) ? oldest_reg : '0;
        slot_inc_w   = CNT_W'(slot_w) + CNT_W'(1);
        fill_after_w = full_w ? k_w : (fill_reg + CNT_W'(1));
    end

    // handshake terms
    assign accept_w    = s_axis_tvalid && s_axis_tready;
    assign scan_done_w = (idx_reg == k_m1_w);
    assign shift_w     = (pos_reg != '0) && (sort_rdata_reg > sample_reg);
    assign out_load_w  = (state_reg == ST_OUT_LOAD) && (!out_valid_reg || m_axis_tready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_w)
                begin
                    state_next = full_w ? ST_REM_FETCH : ST_INS_FETCH;
                end
            end
            ST_REM_FETCH:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_done_w)
                begin
                    state_next = ST_INS_FETCH;
                end
            end
            ST_INS_FETCH:
            begin
                state_next = ST_INS;
            end
            ST_INS:
            begin
                if (!shift_w)
                begin
                    state_next = produce_reg ? ST_MED_RD : ST_IDLE;
                end
            end
            ST_MED_RD:
            begin
                state_next = ST_OUT_LOAD;
            end
            ST_OUT_LOAD:
            begin
                if (out_load_w)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory controls per state
    always_comb
    begin
        s_axis_tready = 1'b0;
        win_we        = 1'b0;
        win_waddr     = full_w ? slot_w : fill_reg[IDX_W-1:0];
        win_raddr     = slot_w;
        sort_we       = 1'b0;
        sort_waddr    = pos_reg;
        sort_wdata    = sample_reg;
        sort_raddr    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                win_we        = accept_w;
            end
            ST_REM_FETCH:
            begin
                sort_raddr = '0;
            end
            ST_SCAN:
            begin
                // read one ahead, move later entries down one place once found
                sort_raddr = idx_reg + IDX_W'(1);
                sort_we    = found_reg;
                sort_waddr = idx_reg - IDX_W'(1);
                sort_wdata = sort_rdata_reg;
            end
            ST_INS_FETCH:
            begin
                sort_raddr = pos_reg - IDX_W'(1);
            end
            ST_INS:
            begin
                // larger entries move up one place, the sample lands in the gap
                sort_raddr = pos_reg - IDX_W'(2);
                sort_we    = 1'b1;
                sort_waddr = pos_reg;
                sort_wdata = shift_w ? sort_rdata_reg : sample_reg;
            end
            ST_MED_RD:
            begin
                sort_raddr = k_m1_w >> 1;
            end
            ST_OUT_LOAD:
            begin
                sort_raddr = k_m1_w >> 1;
            end
            default:
            begin
                sort_raddr = '0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        fill_next      = fill_reg;
        oldest_next    = oldest_reg;
        sample_next    = sample_reg;
        last_next      = last_reg;
        produce_next   = produce_reg;
        old_next       = old_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        // item taken, window bookkeeping settled at once
        if (accept_w)
        begin
            sample_next  = $signed(s_axis_tdata);
            last_next    = s_axis_tlast;
            produce_next = (fill_after_w == k_w);
            pos_next     = full_w ? k_m1_w : fill_reg[IDX_W-1:0];
            fill_next    = fill_after_w;
            if (full_w)
            begin
                oldest_next = (slot_inc_w >= k_w) ? '0 : slot_inc_w[IDX_W-1:0];
            end
            if (s_axis_tlast)
            begin
                fill_next   = '0;
                oldest_next = '0;
            end
        end

        // leaving sample fetched, scan starts at the bottom
        if (state_reg == ST_REM_FETCH)
        begin
            old_next   = win_rdata_reg;
            idx_next   = '0;
            found_next = 1'b0;
        end

        if (state_reg == ST_SCAN)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (!found_reg && (sort_rdata_reg == old_reg))
            begin
                found_next = 1'b1;
            end
        end

        if ((state_reg == ST_INS) && shift_w)
        begin
            pos_next = pos_reg - IDX_W'(1);
        end

        // output register
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load_w)
        begin
            out_valid_next = 1'b1;
            out_data_next  = sort_rdata_reg;
            out_last_next  = last_reg;
        end

        // register write empties the window
        if (cfg_we)
        begin
            fill_next   = '0;
            oldest_next = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            window_size_reg <= CFG_W'(3);
            fill_reg        <= '0;
            oldest_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            oldest_reg    <= oldest_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                window_size_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        last_reg     <= last_next;
        produce_reg  <= produce_next;
        old_reg      <= old_next;
        idx_reg      <= idx_next;
        found_reg    <= found_next;
        pos_reg      <= pos_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    // arrival-order memory
    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[win_waddr] <= $signed(s_axis_tdata);
        end
        win_rdata_reg <= win_mem[win_raddr];
    end

    // sorted memory
    always_ff @(posedge clk)
    begin
        if (sort_we)
        begin
            sort_mem[sort_waddr] <= sort_wdata;
        end
        sort_rdata_reg <= sort_mem[sort_raddr];
    end

    // result port
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // checks
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready
    ) else $error("input accepted while an item was in work");

    a_fill_bounded: assert property (
        @(posedge clk) disable iff (!rst_n)
        fill_reg <= k_w
    ) else $error("window fill count exceeds the window size");

    a_result_from_load: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_OUT_LOAD)
    ) else $error("result shown without an output load");

    a_leaving_found: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && scan_done_w) |-> (found_reg || sort_rdata_reg == old_reg)
    ) else $error("leaving sample missing from the sorted window");

    a_result_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata))
    ) else $error("stalled result changed");

endmodule

`default_nettype wire

/* dv/tb_sliding_window_median.sv */
// ----------------------------------------------------------------------------
// tb_sliding_window_median
// Self-checking bench for the running lower-median filter. Samples go in on
// the s_axis stream, and an in-bench window predictor works out each median
// as the item is accepted. A checker pops that expectation when the m_axis
// result arrives. Both streams idle at random, and the window size register
// is rewritten between phases, covering zero, small, full and saturating sizes.
// ----------------------------------------------------------------------------
module tb_sliding_window_median;

    timeunit 1ns;
    timeprecision 1ps;

    import swm_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int MAX_PAUSE     = 17;
    // wait longer than the worst item cost
    localparam int SETTLE_CYCLES = 2 * WINDOW_MAX + 16;
    localparam int TARGET_ITEMS  = 750;
    localparam int SHOWN_ERRORS  = 10;

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

    typedef enum int {VAL_FULL, VAL_NARROW, VAL_EXTREME} value_mix_t;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] median;
        logic                    seq_end;
    } median_result_t;

    // dut ports
    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    cfg_we        = 1'b0;
    logic [CFG_W-1:0]        cfg_wdata     = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [SAMPLE_WIDTH-1:0] s_axis_tdata  = '0;
    logic                    s_axis_tlast  = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [SAMPLE_WIDTH-1:0] m_axis_tdata;
    logic                    m_axis_tlast;

    // window predictor state
    logic [CFG_W-1:0]               size_reg = 7'd3;
    logic signed [SAMPLE_WIDTH-1:0] arrival_win [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] sorted_win  [WINDOW_MAX];
    int unsigned                    fill_cnt    = 0;
    int unsigned                    oldest_slot = 0;

    median_result_t expected_medians [$];

    bit          src_idle_en  = 1'b1;
    bit          sink_idle_en = 1'b1;
    int unsigned samples_sent = 0;
    int unsigned medians_seen = 0;
    int unsigned seqs_sent    = 0;
    int unsigned size_writes  = 0;
    int unsigned fail_count   = 0;

    sliding_window_median dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] sample
        .s_axis_tlast  (s_axis_tlast),   // last_sample
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] median
        .m_axis_tlast  (m_axis_tlast)    // sequence_end
    );

    // clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // run limit
    initial
    begin
        #8_000_000;
        $display("timeout: %0d samples sent, %0d still expected",
                 samples_sent, expected_medians.size());
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // zero acts as one, anything above the window memory saturates
    function automatic int unsigned active_window();
        if (size_reg == 0)
            return 1;
        if (size_reg > WINDOW_MAX)
            return WINDOW_MAX;
        return int'(size_reg);
    endfunction

    // insert into the first count sorted entries, ascending signed order
    function automatic void sorted_insert(logic signed [SAMPLE_WIDTH-1:0] value,
                                          int unsigned count);
        int unsigned pos;
        pos = count;
        while (pos > 0 && sorted_win[pos-1] > value)
        begin
            sorted_win[pos] = sorted_win[pos-1];
            pos--;
        end
        sorted_win[pos] = value;
    endfunction

    // advance the window by one sample, return 1 when a median comes out
    function automatic bit window_advance(logic signed [SAMPLE_WIDTH-1:0] value, bit last,
                                          output median_result_t res);
        int unsigned k;
        int unsigned slot;
        bit          found;
        bit          produced;
        k        = active_window();
        produced = 1'b0;
        res      = '0;
        if (fill_cnt >= k)
        begin
            slot = (oldest_slot < k) ? oldest_slot : 0;
            // drop one sorted copy of the leaving sample
            found = 1'b0;
            for (int unsigned i = 0; i < k; i++)
            begin
                if (!found && sorted_win[i] == arrival_win[slot])
                    found = 1'b1;
                if (found && i + 1 < k)
                    sorted_win[i] = sorted_win[i+1];
            end
            arrival_win[slot] = value;
            sorted_insert(value, k - 1);
            slot++;
            oldest_slot = (slot >= k) ? 0 : slot;
            fill_cnt    = k;
        end
        else
        begin
            arrival_win[fill_cnt] = value;
            sorted_insert(value, fill_cnt);
            fill_cnt++;
        end
        if (fill_cnt == k)
        begin
            res.median  = sorted_win[(k - 1) / 2];
            res.seq_end = last;
            produced    = 1'b1;
        end
        if (last)
        begin
            fill_cnt    = 0;
            oldest_slot = 0;
        end
        return produced;
    endfunction

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_medians
        median_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            medians_seen++;
            if (expected_medians.size() == 0)
            begin
                fail_count++;
                if (fail_count <= SHOWN_ERRORS)
                    $display("unexpected result: median %0d seq_end %0b",
                             $signed(m_axis_tdata), m_axis_tlast);
            end
            else
            begin
                want = expected_medians.pop_front();
                if (m_axis_tdata !== want.median || m_axis_tlast !== want.seq_end)
                begin
                    fail_count++;
                    if (fail_count <= SHOWN_ERRORS)
                        $display("result %0d: median exp %0d got %0d, seq_end exp %0b got %0b",
                                 medians_seen, $signed(want.median), $signed(m_axis_tdata),
                                 want.seq_end, m_axis_tlast);
                end
            end
        end
    end

    // result side back-pressure
    initial
    begin : sink_ready
        int unsigned pause;
        @(posedge clk iff rst_n);
        forever
        begin
            pause = sink_idle_en ? $urandom_range(0, MAX_PAUSE) : 0;
            if (pause > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // send one sample and record its expected median once accepted
    task automatic send_sample(logic signed [SAMPLE_WIDTH-1:0] value, bit last);
        int unsigned    gap;
        median_result_t res;
        gap = src_idle_en ? $urandom_range(0, MAX_PAUSE) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        samples_sent++;
        if (last)
            seqs_sent++;
        if (window_advance(value, last, res))
            expected_medians = {expected_medians, res};
    endtask

    task automatic wait_medians_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_medians.size() != 0)
            @(posedge clk);
    endtask

    // register write once the block has gone quiet
    task automatic write_window_size(logic [CFG_W-1:0] value);
        wait_medians_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        size_reg    = value;
        fill_cnt    = 0;
        oldest_slot = 0;
        size_writes++;
    endtask

    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample(value_mix_t mix);
        logic signed [SAMPLE_WIDTH-1:0] v;
        v = $urandom;
        case (mix)
            VAL_NARROW:
                v = $signed($urandom_range(0, 8)) - 4;
            VAL_EXTREME:
                case ($urandom_range(0, 5))
                    0: v = SAMPLE_MIN;
                    1: v = SAMPLE_MAX;
                    2: v = 0;
                    3: v = -1;
                    4: v = 1;
                    default: ;
                endcase
            default: ;
        endcase
        return v;
    endfunction

    // a run of samples, closed by a flagged last sample when asked
    task automatic send_sequence(int unsigned len, bit close, value_mix_t mix);
        for (int unsigned i = 0; i < len; i++)
            send_sample(pick_sample(mix), close && (i == len - 1));
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset window of three: extreme values, equal samples, short sequences
    task automatic test_directed_edges();
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(0, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(5, 1'b0);
        send_sample(5, 1'b1);
        // last sample before the window fills gives nothing
        send_sample(7, 1'b0);
        send_sample(7, 1'b1);
        send_sample(SAMPLE_MIN, 1'b1);
        // repeated values leaving one copy at a time
        send_sample(-1, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(2, 1'b0);
        send_sample(-1, 1'b0);
        send_sample(2, 1'b0);
        send_sample(2, 1'b1);
    endtask

    // zero, one, two, the full window and saturating register values
    task automatic test_window_size_extremes();
        logic [CFG_W-1:0] sizes [6] = '{7'd0, 7'd1, 7'd2, 7'd64, 7'd127, 7'd65};
        foreach (sizes[i])
        begin
            write_window_size(sizes[i]);
            send_sequence(active_window() + 8 + $urandom_range(0, 4), 1'b1,
                          value_mix_t'($urandom_range(0, 2)));
        end
    endtask

    // sender holds off mid-sequence until every median is out
    task automatic test_drain_hold();
        write_window_size(7'd5);
        send_sequence(9, 1'b0, VAL_FULL);
        wait_medians_drained();
        send_sequence(8, 1'b1, VAL_NARROW);
        send_sequence(2, 1'b0, VAL_EXTREME);
        wait_medians_drained();
        send_sequence(10, 1'b1, VAL_FULL);
    endtask

    // mostly well-formed sequences at mostly small sizes, some cut short
    task automatic test_random_sequences();
        int unsigned k;
        int unsigned seq_total;
        int unsigned len;
        int unsigned pick;
        bit          close;
        while (samples_sent < TARGET_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 6)
                write_window_size(CFG_W'($urandom_range(1, 8)));
            else if (pick <= 8)
                write_window_size(CFG_W'($urandom_range(9, 24)));
            else
                write_window_size(CFG_W'($urandom_range(25, 127)));
            k         = active_window();
            seq_total = $urandom_range(2, 5);
            for (int unsigned s = 0; s < seq_total; s++)
            begin
                // some stretches run with no idling on either side
                src_idle_en  = ($urandom_range(0, 4) != 0);
                sink_idle_en = ($urandom_range(0, 4) != 0);
                if (k > 1 && $urandom_range(0, 7) == 0)
                    len = $urandom_range(1, k - 1);
                else
                    len = k + $urandom_range(1, 24);
                // a phase may end mid-sequence, so the register write clears it
                close = (s + 1 < seq_total) || ($urandom_range(0, 3) != 0);
                send_sequence(len, close, value_mix_t'($urandom_range(0, 2)));
            end
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_window_size_extremes();
        test_drain_hold();
        test_random_sequences();

        wait_medians_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_medians.size() != 0)
        begin
            fail_count += expected_medians.size();
            $display("%0d expected medians never arrived", expected_medians.size());
        end

        $display("covered %0d samples in %0d closed sequences over %0d window size writes",
                 samples_sent, samples_sent == 0 ? 0 : seqs_sent, size_writes);
        $display("%0d medians checked, %0d failures", medians_seen, fail_count);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
